[design/lsqm_pkg.sv]
// Shared constants and types for the largest square in mask unit.
`timescale 1ns / 1ps

package lsqm_pkg;

    localparam int MASK_W   = 8;
    localparam int THRESH_W = 8;
    localparam int LIMIT_W  = 9;
    localparam int SIZE_W   = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam int SIDE_OUT_W = 9;
    localparam int POS_OUT_W  = 8;
    localparam int CROP_OUT_W = 9;
    localparam int RESULT_W   = SIDE_OUT_W + 2 * POS_OUT_W + 3 * CROP_OUT_W;
    localparam int TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd200;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 9'd256;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_THRESHOLD = 2'd0,
        CFG_CROP_LIMIT    = 2'd1,
        CFG_FRAME_COLS    = 2'd2,
        CFG_FRAME_ROWS    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CROP_OUT_W-1:0] crop_side;
        logic [CROP_OUT_W-1:0] crop_col;
        logic [CROP_OUT_W-1:0] crop_row;
        logic [POS_OUT_W-1:0]  end_col;
        logic [POS_OUT_W-1:0]  end_row;
        logic [SIDE_OUT_W-1:0] max_side;
    } result_t;

endpackage

[design/lsqm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lsqm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/largest_square_in_mask_unit.sv]
// Largest all-set square in a raster mask, with a centered crop window.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | one mask pixel per beat, raster order
//  m_axis   | out | one result beat per frame: side, end position, crop window
//  cfg      | in  | register write: threshold, crop limit, frame cols, frame rows
//
//  One pixel beat per cycle unless stalled. The row memory is read on accept
//  and written when that pixel leaves stage 1; a write to the entry being read
//  in that cycle is forwarded. A frame's result passes from stage 1 through
//  the finish stage into the result register. No clearing pass after reset:
//  a fill count marks the entries written in the current frame. Input stalls
//  only when a frame-end pixel meets a full result register and a full finish stage.
`timescale 1ns / 1ps

module largest_square_in_mask_unit #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsqm_pkg::MASK_W-1:0]         s_axis_tdata,   // [7:0] mask_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [8:0] max_side, [16:9] end_row, [24:17] end_col, [33:25] crop_row,
    // [42:34] crop_col, [51:43] crop_side, [55:52] zero
    output logic [lsqm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [lsqm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsqm_pkg::CFG_W-1:0]          cfg_data
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CLW    = (CCNT_W > lsqm_pkg::SIZE_W) ? CCNT_W : lsqm_pkg::SIZE_W;
    localparam int RLW    = (RCNT_W > lsqm_pkg::SIZE_W) ? RCNT_W : lsqm_pkg::SIZE_W;
    localparam int MIN_DIM = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int SW     = $clog2(MIN_DIM + 1);
    localparam int MW     = (SW > lsqm_pkg::LIMIT_W) ? SW : lsqm_pkg::LIMIT_W;
    localparam int OW     = lsqm_pkg::CROP_OUT_W;

    // configuration
    logic [lsqm_pkg::THRESH_W-1:0] thresh_reg;
    logic [lsqm_pkg::LIMIT_W-1:0]  limit_reg;
    logic [lsqm_pkg::SIZE_W-1:0]   fcols_reg;
    logic [lsqm_pkg::SIZE_W-1:0]   frows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= lsqm_pkg::THRESH_RESET;
            limit_reg  <= lsqm_pkg::LIMIT_RESET;
            fcols_reg  <= lsqm_pkg::SIZE_RESET;
            frows_reg  <= lsqm_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (lsqm_pkg::cfg_index_t'(cfg_index))
                lsqm_pkg::CFG_SET_THRESHOLD: thresh_reg <= cfg_data[lsqm_pkg::THRESH_W-1:0];
                lsqm_pkg::CFG_CROP_LIMIT:    limit_reg  <= cfg_data[lsqm_pkg::LIMIT_W-1:0];
                lsqm_pkg::CFG_FRAME_COLS:    fcols_reg  <= cfg_data[lsqm_pkg::SIZE_W-1:0];
                lsqm_pkg::CFG_FRAME_ROWS:    frows_reg  <= cfg_data[lsqm_pkg::SIZE_W-1:0];
            endcase
        end
    end

    // position counters and fill count, advanced on accept
    logic [COL_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [CCNT_W-1:0] fill_reg;

    logic [CLW-1:0]    cols_w;
    logic [RLW-1:0]    rows_w;
    logic [CLW-1:0]    col_inc;
    logic [RLW-1:0]    row_inc;
    logic              row_end;
    logic              frame_end;
    logic              up_ok;
    logic [CCNT_W-1:0] fill_next;
    logic              accept;

    always_comb
    begin
        if (fcols_reg == '0)
            cols_w = CLW'(1);
        else if (CLW'(fcols_reg) > CLW'(MAX_COLS))
            cols_w = CLW'(MAX_COLS);
        else
            cols_w = CLW'(fcols_reg);

        if (frows_reg == '0)
            rows_w = RLW'(1);
        else if (RLW'(frows_reg) > RLW'(MAX_ROWS))
            rows_w = RLW'(MAX_ROWS);
        else
            rows_w = RLW'(frows_reg);

        col_inc   = CLW'(col_count_reg) + CLW'(1);
        row_inc   = RLW'(row_count_reg) + RLW'(1);
        row_end   = (col_inc >= cols_w);
        frame_end = row_end && (row_inc >= rows_w);
        up_ok     = (row_count_reg != '0) && (CCNT_W'(col_count_reg) < fill_reg);

        if (frame_end)
            fill_next = '0;
        else if (CCNT_W'(col_inc) > fill_reg)
            fill_next = CCNT_W'(col_inc);
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            fill_reg      <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            if (row_end)
            begin
                col_count_reg <= '0;
                row_count_reg <= frame_end ? '0 : ROW_W'(row_inc);
            end
            else
            begin
                col_count_reg <= COL_W'(col_inc);
            end
        end
    end

    // stage 1: row memory data available, side computed, written back on leave
    logic              s1_valid_reg;
    logic              s1_set_reg;
    logic              s1_up_ok_reg;
    logic              s1_last_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              fwd_hit_reg;
    logic [SW-1:0]     fwd_data_reg;
    logic [SW-1:0]     ram_rdata;

    logic [SW-1:0]     left_reg;
    logic [SW-1:0]     diag_reg;
    logic [SW-1:0]     best_side_reg;
    logic [ROW_W-1:0]  best_row_reg;
    logic [COL_W-1:0]  best_col_reg;

    logic              fin_valid_reg;
    logic [SW-1:0]     fin_side_reg;
    logic [ROW_W-1:0]  fin_row_reg;
    logic [COL_W-1:0]  fin_col_reg;

    logic              out_valid_reg;
    lsqm_pkg::result_t out_reg;

    logic              out_free;
    logic              fin_move;
    logic              fin_free;
    logic              s1_adv;
    logic              s1_leave;

    logic [SW-1:0]     up_w;
    logic [SW-1:0]     dg_w;
    logic [SW-1:0]     lf_w;
    logic [SW-1:0]     min_w;
    logic [SW-1:0]     side_w;
    logic              take_best;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fin_move      = fin_valid_reg && out_free;
    assign fin_free      = !fin_valid_reg || out_free;
    assign s1_adv        = !s1_last_reg || fin_free;
    assign s1_leave      = s1_valid_reg && s1_adv;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (!s1_up_ok_reg)
            up_w = '0;
        else if (fwd_hit_reg)
            up_w = fwd_data_reg;
        else
            up_w = ram_rdata;

        dg_w = (s1_row_reg == '0 || s1_col_reg == '0) ? '0 : diag_reg;
        lf_w = (s1_col_reg == '0) ? '0 : left_reg;

        min_w = (up_w < dg_w) ? up_w : dg_w;
        if (lf_w < min_w)
            min_w = lf_w;

        side_w    = s1_set_reg ? min_w + SW'(1) : '0;
        take_best = (side_w >= best_side_reg);
    end

    lsqm_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .clk   (clk),
        .we    (s1_leave),
        .waddr (s1_col_reg),
        .wdata (side_w),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg   <= (s_axis_tdata > thresh_reg);
            s1_up_ok_reg <= up_ok;
            s1_last_reg  <= frame_end;
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
            fwd_hit_reg  <= s1_leave && (s1_col_reg == col_count_reg);
            fwd_data_reg <= side_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (s1_leave)
        begin
            left_reg <= side_w;
            diag_reg <= up_w;
            if (s1_last_reg)
            begin
                best_side_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else if (take_best)
            begin
                best_side_reg <= side_w;
                best_row_reg  <= s1_row_reg;
                best_col_reg  <= s1_col_reg;
            end
        end
    end

    // finish stage: final best of the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (s1_leave && s1_last_reg)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_move)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave && s1_last_reg)
        begin
            fin_side_reg <= take_best ? side_w : best_side_reg;
            fin_row_reg  <= take_best ? s1_row_reg : best_row_reg;
            fin_col_reg  <= take_best ? s1_col_reg : best_col_reg;
        end
    end

    // result register: crop window
    logic [MW-1:0] crop_side_w;
    logic [MW-1:0] crop_off_w;
    logic [OW-1:0] crop_base_r;
    logic [OW-1:0] crop_base_c;

    always_comb
    begin
        crop_side_w = (MW'(fin_side_reg) < MW'(limit_reg)) ? MW'(fin_side_reg)
                                                           : MW'(limit_reg);
        crop_off_w  = (MW'(fin_side_reg) - crop_side_w) >> 1;
        crop_base_r = OW'(fin_row_reg) + OW'(1) - OW'(fin_side_reg) + OW'(crop_off_w);
        crop_base_c = OW'(fin_col_reg) + OW'(1) - OW'(fin_side_reg) + OW'(crop_off_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_move)
        begin
            out_reg.max_side  <= lsqm_pkg::SIDE_OUT_W'(fin_side_reg);
            out_reg.end_row   <= lsqm_pkg::POS_OUT_W'(fin_row_reg);
            out_reg.end_col   <= lsqm_pkg::POS_OUT_W'(fin_col_reg);
            out_reg.crop_row  <= crop_base_r;
            out_reg.crop_col  <= crop_base_c;
            out_reg.crop_side <= OW'(crop_side_w);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = lsqm_pkg::TDATA_OUT_W'(out_reg);

    // checks
    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !s_axis_tready)
        else $error("input accepted while stage 1 holds");

    a_fill_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CCNT_W'(MAX_COLS))
        else $error("fill count beyond row memory depth");

    a_frame_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> (col_count_reg == '0 && row_count_reg == '0
                                   && fill_reg == '0))
        else $error("position not cleared after frame end");

    a_best_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        best_side_reg <= SW'(MIN_DIM))
        else $error("best side exceeds frame bounds");

endmodule
